/* src/comet_tail_renderer_assert.svh */
// Assertion macros shared by the comet tail renderer modules.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef COMET_TAIL_RENDERER_ASSERT_SVH
`define COMET_TAIL_RENDERER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define CTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property on every rising clock edge, reset included.
`define CTR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define CTR_ASSERT(label, clk, rst, prop)
`define CTR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* src/ctr_pkg.sv */
// Types and constants of the comet tail renderer.
// Used by the shared divider, the top level and the testbench; depends on nothing.
package ctr_pkg;

   localparam int DIV_W = 32;   // dividend and quotient width
   localparam int DEN_W = 16;   // divisor and remainder width
   localparam int CNT_W = 6;    // step counter, holds DIV_W

   // step counts for the three uses of the divider
   localparam logic [CNT_W-1:0] STEPS_SIZE  = 6'd8;
   localparam logic [CNT_W-1:0] STEPS_POS   = 6'd32;
   localparam logic [CNT_W-1:0] STEPS_COLOR = 6'd16;

   // configuration register indexes
   localparam logic [2:0] CSR_SEG_START    = 3'd0;
   localparam logic [2:0] CSR_SEG_LENGTH   = 3'd1;
   localparam logic [2:0] CSR_FIRST_COLOR  = 3'd2;
   localparam logic [2:0] CSR_SECOND_COLOR = 3'd3;
   localparam logic [2:0] CSR_COMET_SIZE   = 3'd4;
   localparam logic [2:0] CSR_REVERSE_DIR  = 3'd5;
   localparam logic [2:0] CSR_RING_LENGTH  = 3'd6;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;   // aligned to the top bit
      logic [DEN_W-1:0] divisor;
      logic [CNT_W-1:0] steps;      // dividend bits to consume
   } ctr_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;       // one-cycle pulse, results valid
      logic [DIV_W-1:0] quotient;
      logic [DEN_W-1:0] remainder;
   } ctr_div_res_type;

endpackage

/* src/ctr_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all modulo and blend steps.
// Depends on ctr_pkg and the assertion header.
`include "comet_tail_renderer_assert.svh"

module ctr_divider
   import ctr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctr_div_req_type div_req,
   output ctr_div_res_type div_res
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, subtract if it fits
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_res.busy      = busy_ff;
   assign div_res.done      = done_ff;
   assign div_res.quotient  = quo_ff;
   assign div_res.remainder = rem_ff;

   `CTR_ASSERT(a_no_start_when_busy, clock, reset, div_req.start |-> !busy_ff)
   `CTR_ASSERT(a_done_after_last_step, clock, reset,
      (busy_ff && !div_req.start && cnt_ff == CNT_W'(1)) |=> (done_ff && !busy_ff))
   `CTR_ASSERT(a_done_not_busy, clock, reset, done_ff |-> !busy_ff)

endmodule

/* src/comet_tail_renderer.sv */
// Comet tail renderer: one frame position in, one colour write per segment pixel out.
// Each accepted item is worked on alone; req_tready is high only while the block is idle.
// Setup is two passes of the shared bit-serial divider: 8 steps for the trail size less
// one modulo the ring and 32 steps for the position modulo the ring. Each pixel then
// goes straight from the lookup to the output when it is black or the comet is one
// pixel long. Otherwise its colour is blended: each of the three channels forms its
// numerator and then runs a 16-step pass of the same divider. A stalled rsp_tready
// holds the sequencer.
// Depends on ctr_pkg, ctr_divider and the assertion header.
`include "comet_tail_renderer_assert.svh"

module comet_tail_renderer
   import ctr_pkg::*;
#(
   parameter int STRIP_PIXELS = 1024,
   parameter int SEG_MAX      = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   // frame commands
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] frame_pos (signed)
   // pixel writes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [9:0] pixel_index, [33:10] pixel_color, rest zero
   output logic        rsp_tlast    // last_pixel
);

   localparam logic [16:0] STRIP_L   = 17'(STRIP_PIXELS);
   localparam logic [6:0]  SEG_MAX_L = 7'(SEG_MAX);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MODSZ  = 3'd1;
   localparam logic [2:0] S_MODPOS = 3'd2;
   localparam logic [2:0] S_PIX    = 3'd3;
   localparam logic [2:0] S_NUM    = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   // configuration
   logic [9:0]  seg_start_ff;
   logic [6:0]  seg_length_ff;
   logic [23:0] first_color_ff;
   logic [23:0] second_color_ff;
   logic [7:0]  comet_size_ff;
   logic        reverse_dir_ff;
   logic [15:0] ring_length_ff;

   // sequencer
   logic [2:0]  state_ff, state_in;
   logic [31:0] pos_ff, pos_in;
   logic [6:0]  len_ff, len_in;
   logic [15:0] ring_ff, ring_in;
   logic [7:0]  r0_ff, r0_in;
   logic [15:0] head_ff, head_in;
   logic [6:0]  k_ff, k_in;
   logic [7:0]  i_ff, i_in;
   logic [1:0]  ch_ff, ch_in;
   logic [15:0] num_ff, num_in;
   logic [23:0] color_ff, color_in;

   ctr_div_req_type div_req;
   ctr_div_res_type div_res;

   // combinational helpers
   logic [16:0] room;
   logic [6:0]  len_cfg;
   logic        empty_cfg;
   logic [15:0] ring_cfg;
   logic [31:0] pos_mag;
   logic [6:0]  v;
   logic [16:0] d_wide;
   logic [15:0] d;
   logic        hit;
   logic [7:0]  size_m1;
   logic [16:0] i_wide;
   logic [7:0]  ca, cb;

   ctr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   // effective segment length and ring length from the registers
   always_comb begin
      room    = STRIP_L - {7'b0, seg_start_ff};
      len_cfg = (seg_length_ff > SEG_MAX_L) ? SEG_MAX_L : seg_length_ff;
      if ({7'b0, seg_start_ff} >= STRIP_L) begin
         len_cfg = '0;
      end else if ({10'b0, len_cfg} > room) begin
         len_cfg = room[6:0];
      end
      empty_cfg = (len_cfg == '0) || (comet_size_ff == '0);
      ring_cfg  = (ring_length_ff != '0) ? ring_length_ff : {9'b0, len_cfg};
   end

   // per-pixel trail lookup: largest trail index i that lands on this pixel
   always_comb begin
      size_m1 = comet_size_ff - 1'b1;
      pos_mag = pos_ff[31] ? (32'd0 - pos_ff) : pos_ff;
      v       = reverse_dir_ff ? (len_ff - 7'd1 - k_ff) : k_ff;
      if (head_ff >= {9'b0, v}) begin
         d_wide = {1'b0, head_ff} - {10'b0, v};
      end else begin
         d_wide = {1'b0, head_ff} + {1'b0, ring_ff} - {10'b0, v};
      end
      d   = d_wide[15:0];
      hit = ({9'b0, v} < ring_ff) && (d < {8'b0, comet_size_ff});
      if (d <= {8'b0, r0_ff}) begin
         i_wide = {9'b0, size_m1} - {9'b0, r0_ff} + {1'b0, d};
      end else begin
         i_wide = {9'b0, size_m1} - {9'b0, r0_ff} + {1'b0, d} - {1'b0, ring_ff};
      end
      ca = first_color_ff[ch_ff*8 +: 8];
      cb = second_color_ff[ch_ff*8 +: 8];
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      ring_in  = ring_ff;
      r0_in    = r0_ff;
      head_in  = head_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      ch_in    = ch_ff;
      num_in   = num_ff;
      color_in = color_ff;
      div_req  = '{start: 1'b0, dividend: '0, divisor: ring_ff, steps: STEPS_POS};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !empty_cfg) begin
               pos_in  = req_tdata;
               len_in  = len_cfg;
               ring_in = ring_cfg;
               k_in    = '0;
               div_req = '{start: 1'b1, dividend: {size_m1, 24'b0},
                           divisor: ring_cfg, steps: STEPS_SIZE};
               state_in = S_MODSZ;
            end
         end
         S_MODSZ: begin
            if (div_res.done) begin
               r0_in   = div_res.remainder[7:0];
               div_req = '{start: 1'b1, dividend: pos_mag,
                           divisor: ring_ff, steps: STEPS_POS};
               state_in = S_MODPOS;
            end
         end
         S_MODPOS: begin
            if (div_res.done) begin
               // negative positions wrap to the non-negative remainder
               if (pos_ff[31] && div_res.remainder != '0) begin
                  head_in = ring_ff - div_res.remainder;
               end else begin
                  head_in = div_res.remainder;
               end
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            i_in = i_wide[7:0];
            if (!hit) begin
               color_in = '0;
               state_in = S_EMIT;
            end else if (comet_size_ff == 8'd1) begin
               color_in = second_color_ff;
               state_in = S_EMIT;
            end else begin
               ch_in    = 2'd2;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            num_in = 16'({8'b0, ca} * {8'b0, size_m1 - i_ff})
                   + 16'({8'b0, cb} * {8'b0, i_ff});
            state_in = S_DIV;
         end
         S_DIV: begin
            div_req.divisor = {8'b0, size_m1};
            div_req.steps   = STEPS_COLOR;
            div_req.dividend = {num_ff, 16'b0};
            if (!div_res.busy && !div_res.done) begin
               div_req.start = 1'b1;
            end
            if (div_res.done) begin
               color_in[ch_ff*8 +: 8] = div_res.quotient[7:0];
               if (ch_ff == 2'd0) begin
                  state_in = S_EMIT;
               end else begin
                  ch_in    = ch_ff - 2'd1;
                  state_in = S_NUM;
               end
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (k_ff == len_ff - 7'd1) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 7'd1;
                  state_in = S_PIX;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         seg_start_ff    <= 10'd0;
         seg_length_ff   <= 7'd64;
         first_color_ff  <= 24'd0;
         second_color_ff <= 24'd0;
         comet_size_ff   <= 8'd1;
         reverse_dir_ff  <= 1'b0;
         ring_length_ff  <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SEG_START:    seg_start_ff    <= csr_data[9:0];
               CSR_SEG_LENGTH:   seg_length_ff   <= csr_data[6:0];
               CSR_FIRST_COLOR:  first_color_ff  <= csr_data;
               CSR_SECOND_COLOR: second_color_ff <= csr_data;
               CSR_COMET_SIZE:   comet_size_ff   <= csr_data[7:0];
               CSR_REVERSE_DIR:  reverse_dir_ff  <= csr_data[0];
               CSR_RING_LENGTH:  ring_length_ff  <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      ring_ff  <= ring_in;
      r0_ff    <= r0_in;
      head_ff  <= head_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      ch_ff    <= ch_in;
      num_ff   <= num_in;
      color_ff <= color_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tlast  = (k_ff == len_ff - 7'd1);
   assign rsp_tdata  = {6'b0, color_ff, 10'(seg_start_ff + {3'b0, k_ff})};

   `CTR_ASSERT(a_pixel_in_segment, clock, reset, rsp_tvalid |-> (k_ff < len_ff))
   `CTR_ASSERT(a_gap_between_pixels, clock, reset,
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> !rsp_tvalid)
   `CTR_ASSERT(a_idle_after_last, clock, reset,
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
   `CTR_ASSERT(a_busy_after_accept, clock, reset,
      (req_tvalid && req_tready && !empty_cfg) |=> !req_tready)

endmodule

/* tb/comet_pixel_checker.sv */
`timescale 1ns / 100ps
// Pixel write checker for the comet tail renderer: tracks register writes, works out the
// writes of every accepted frame position and compares the pixel stream against them.
// Depends on ctr_pkg for the register indexes.
module comet_pixel_checker
   import ctr_pkg::*;
#(
   parameter int STRIP_PIXELS = 1024,
   parameter int SEG_MAX      = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] frame_pos (signed)
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [9:0] pixel_index, [33:10] pixel_color, rest zero
   input  logic        rsp_tlast,   // last_pixel
   output int          err_count,
   output int          pending,
   output int          pix_count
);

   localparam int MAX_LINES = 100;

   typedef struct {
      logic [9:0]  index;
      logic [23:0] color;
      logic        last;
   } pix_write_type;

   pix_write_type due_writes [$];

   logic [9:0]  base_px;
   logic [6:0]  span_cfg;
   logic [23:0] rgb_head;
   logic [23:0] rgb_tail;
   logic [7:0]  trail_len;
   logic        mirrored;
   logic [15:0] ring_cfg;

   int errors    = 0;
   int pix_total = 0;
   int queued    = 0;

   assign err_count = errors;
   assign pix_count = pix_total;
   assign pending   = queued;

   task automatic report_mismatch(input string what);
      if (errors < MAX_LINES) begin
         $display("%0t ns: pixel mismatch: %s", $time, what);
      end
      errors++;
   endtask

   // Per-channel blend from head colour to tail colour, truncating.
   function automatic logic [23:0] blend_at(input int unsigned i);
      int unsigned den, ch, a, b, mix;
      logic [23:0] c;
      if (trail_len <= 1) return rgb_tail;
      den = trail_len - 1;
      c = '0;
      for (ch = 0; ch < 3; ch++) begin
         a = (rgb_head >> (8 * ch)) & 8'hFF;
         b = (rgb_tail >> (8 * ch)) & 8'hFF;
         mix = (a * (den - i) + b * i) / den;
         c[8 * ch +: 8] = mix[7:0];
      end
      return c;
   endfunction

   function automatic void paint_frame(input logic [31:0] pos_bits);
      logic [23:0] shade [SEG_MAX];
      int unsigned span, ring, head, back, v, off, i, k;
      longint pos, rem;
      pix_write_type w;
      if (trail_len == 0 || int'(base_px) >= STRIP_PIXELS) return;
      span = span_cfg;
      if (span > SEG_MAX) span = SEG_MAX;
      if (span > STRIP_PIXELS - int'(base_px)) span = STRIP_PIXELS - int'(base_px);
      if (span == 0) return;
      ring = (ring_cfg != 0) ? ring_cfg : span;
      pos = $signed(pos_bits);
      rem = pos % longint'(ring);
      if (rem < 0) rem = rem + longint'(ring);
      head = 32'(rem);
      for (k = 0; k < SEG_MAX; k++) shade[k] = '0;
      // later trail pixels overwrite earlier ones where they overlap
      for (i = 0; i < trail_len; i++) begin
         back = i % ring;
         v = (head >= back) ? head - back : head + ring - back;
         if (v < span) begin
            off = mirrored ? span - 1 - v : v;
            shade[off] = blend_at(i);
         end
      end
      for (k = 0; k < span; k++) begin
         w.index = 10'(int'(base_px) + k);
         w.color = shade[k];
         w.last  = (k + 1 == span);
         due_writes.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      pix_write_type w;
      if (reset) begin
         base_px   = '0;
         span_cfg  = 7'd64;
         rgb_head  = '0;
         rgb_tail  = '0;
         trail_len = 8'd1;
         mirrored  = 1'b0;
         ring_cfg  = '0;
         due_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEG_START:    base_px   = csr_data[9:0];
               CSR_SEG_LENGTH:   span_cfg  = csr_data[6:0];
               CSR_FIRST_COLOR:  rgb_head  = csr_data;
               CSR_SECOND_COLOR: rgb_tail  = csr_data;
               CSR_COMET_SIZE:   trail_len = csr_data[7:0];
               CSR_REVERSE_DIR:  mirrored  = csr_data[0];
               CSR_RING_LENGTH:  ring_cfg  = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) paint_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            pix_total++;
            if (due_writes.size() == 0) begin
               report_mismatch($sformatf("write to pixel %0d with no frame pending",
                                         rsp_tdata[9:0]));
            end else begin
               w = due_writes.pop_front();
               if (rsp_tdata[9:0] !== w.index)
                  report_mismatch($sformatf("index %0d, want %0d", rsp_tdata[9:0], w.index));
               if (rsp_tdata[33:10] !== w.color)
                  report_mismatch($sformatf("pixel %0d color %06h, want %06h",
                                            w.index, rsp_tdata[33:10], w.color));
               if (rsp_tlast !== w.last)
                  report_mismatch($sformatf("pixel %0d last %b, want %b",
                                            w.index, rsp_tlast, w.last));
               if (rsp_tdata[39:34] !== '0)
                  report_mismatch($sformatf("pixel %0d padding %h not zero",
                                            w.index, rsp_tdata[39:34]));
            end
         end
      end
      queued <= due_writes.size();
   end

endmodule

/* tb/tb_comet_tail_renderer.sv */
`timescale 1ns / 100ps
// Testbench top for the comet tail renderer: clock, reset, register setup, frame
// stimulus with random idling on both sides, a stall watchdog and the verdict.
// Depends on ctr_pkg, the renderer RTL and comet_pixel_checker.
module tb_comet_tail_renderer
   import ctr_pkg::*;
();

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   localparam int TARGET_FRAMES = 350;
   localparam int IDLE_PCT      = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;
   localparam int STALL_LIMIT   = 8000;

   typedef struct {
      logic [9:0]  start;
      logic [6:0]  span;
      logic [23:0] head_rgb;
      logic [23:0] tail_rgb;
      logic [7:0]  size;
      logic        rev;
      logic [15:0] ring;
   } comet_cfg_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] frame_pos (signed)
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [9:0] pixel_index, [33:10] pixel_color, rest zero
   logic        rsp_tlast;   // last_pixel

   int err_count;
   int pending;
   int pix_count;

   bit calm     = 1'b0;
   bit hold_off = 1'b0;
   int frames_sent = 0;
   int cfg_phases  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   comet_tail_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   comet_pixel_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .err_count  (err_count),
      .pending    (pending),
      .pix_count  (pix_count)
   );

   function automatic comet_cfg_type make_cfg(input logic [9:0] start,
                                              input logic [6:0] span,
                                              input logic [23:0] head_rgb,
                                              input logic [23:0] tail_rgb,
                                              input logic [7:0] size, input logic rev,
                                              input logic [15:0] ring);
      comet_cfg_type c;
      c.start    = start;
      c.span     = span;
      c.head_rgb = head_rgb;
      c.tail_rgb = tail_rgb;
      c.size     = size;
      c.rev      = rev;
      c.ring     = ring;
      return c;
   endfunction

   // Fill the bits above a register's width with noise the block must drop.
   function automatic logic [23:0] padded(input logic [23:0] v, input int w, input bit junk);
      return junk ? (v | (24'($urandom) << w)) : v;
   endfunction

   function automatic comet_cfg_type pick_cfg(input bit heavy);
      comet_cfg_type c;
      case ($urandom_range(0, 3))
         0: c.start = 10'd0;
         1: c.start = 10'(1024 - $urandom_range(1, 24));
         default: c.start = 10'($urandom_range(0, 1023));
      endcase
      if (heavy)
         c.span = 7'($urandom_range(33, 127));
      else if ($urandom_range(0, 11) == 0)
         c.span = 7'd0;
      else
         c.span = 7'($urandom_range(1, 16));
      if (heavy) begin
         c.size = 8'($urandom_range(0, 255));
      end else begin
         case ($urandom_range(0, 9))
            0: c.size = 8'd0;
            1: c.size = 8'd1;
            default: c.size = 8'($urandom_range(2, 8));
         endcase
      end
      c.head_rgb = 24'($urandom);
      c.tail_rgb = 24'($urandom);
      c.rev      = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: c.ring = 16'd0;
         1: c.ring = 16'($urandom_range(1, 20));
         2: c.ring = 16'($urandom_range(0, 65535));
         default: c.ring = 16'hFFFF;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4, 5: return $urandom;
         6, 7: return 32'($urandom_range(0, 300));
         default: return -32'($urandom_range(1, 300));
      endcase
   endfunction

   // Leave csr_valid high between writes; the caller drops it after the last one.
   task automatic put_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_cfg(input comet_cfg_type c, input bit junk);
      put_reg(CSR_SEG_START,    padded(24'(c.start), 10, junk));
      put_reg(CSR_SEG_LENGTH,   padded(24'(c.span), 7, junk));
      put_reg(CSR_FIRST_COLOR,  c.head_rgb);
      put_reg(CSR_SECOND_COLOR, c.tail_rgb);
      put_reg(CSR_COMET_SIZE,   padded(24'(c.size), 8, junk));
      put_reg(CSR_REVERSE_DIR,  padded(24'(c.rev), 1, junk));
      put_reg(CSR_RING_LENGTH,  padded(24'(c.ring), 16, junk));
      if (junk) put_reg(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
      cfg_phases++;
   endtask

   task automatic send_frame(input logic [31:0] pos);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pos;
      do @(posedge clock); while (!req_tready);
      frames_sent++;
   endtask

   // Drain all outstanding writes, then give a frame with no output time to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int k;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_comet_tail_renderer: errors");
      $finish;
   end

   initial begin : stimulus
      comet_cfg_type c;
      int n, k, phase_no;
      bit heavy;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full segment, single black pixel
      send_frame(32'd0);
      send_frame(32'hFFFF_FFFF);
      settle();

      // short segment, head at both ends, wrap, extreme positions
      apply_cfg(make_cfg(10'd0, 7'd8, 24'hFFFFFF, 24'h000000, 8'd4, 1'b0, 16'd0), 1'b1);
      send_frame(32'd0);
      send_frame(32'd3);
      send_frame(32'hFFFF_FFFF);
      send_frame(32'd7);
      send_frame(32'h7FFF_FFFF);
      send_frame(32'h8000_0000);
      settle();

      // mirrored, trail longer than the ring so pixels overlap
      apply_cfg(make_cfg(10'd0, 7'd8, 24'h123456, 24'hABCDEF, 8'd20, 1'b1, 16'd0), 1'b0);
      send_frame(32'd2);
      send_frame(-32'sd5);
      settle();

      // ring shorter than the segment
      apply_cfg(make_cfg(10'd100, 7'd8, 24'($urandom), 24'($urandom), 8'd2, 1'b0, 16'd3),
                1'b0);
      send_frame(32'd10);
      send_frame(-32'sd7);
      settle();

      // longest ring, segment clipped at strip end, full size trail
      apply_cfg(make_cfg(10'd1010, 7'd16, 24'h00FF00, 24'hFF0000, 8'd255, 1'b1, 16'hFFFF),
                1'b0);
      send_frame(32'd65534);
      send_frame(32'd13);
      send_frame(32'd70000);
      settle();

      // zero size, then empty segment: no output at all
      apply_cfg(make_cfg(10'd0, 7'd8, 24'hFFFFFF, 24'hFFFFFF, 8'd0, 1'b0, 16'd0), 1'b0);
      send_frame(32'd5);
      settle();
      apply_cfg(make_cfg(10'd0, 7'd0, 24'hFFFFFF, 24'hFFFFFF, 8'd3, 1'b0, 16'd0), 1'b0);
      send_frame(32'd1);
      settle();

      // last strip pixel alone, single-pixel comet, ring of one
      apply_cfg(make_cfg(10'd1023, 7'd127, 24'h000000, 24'hFFFFFF, 8'd1, 1'b0, 16'd1), 1'b0);
      send_frame($urandom);
      send_frame(32'd0);
      settle();

      // length above the segment limit, full trail across the segment
      apply_cfg(make_cfg(10'd0, 7'd100, 24'hFF00FF, 24'h00FF00, 8'd255, 1'b0, 16'd0), 1'b0);
      send_frame(32'd63);
      settle();

      apply_cfg(make_cfg(10'd960, 7'd64, 24'h000000, 24'hFFFFFF, 8'd2, 1'b1, 16'd0), 1'b0);
      send_frame(32'd0);
      settle();

      phase_no = 0;
      while (frames_sent < TARGET_FRAMES) begin
         heavy = (phase_no != 3) && ($urandom_range(0, 9) == 0);
         calm  = (phase_no >= 6 && phase_no <= 9);
         c = pick_cfg(heavy);
         if (phase_no == 3) begin
            // small frames while the receiver holds off, so the block backs up
            c.span = 7'd6;
            c.size = 8'd3;
            c.ring = 16'd0;
            calm   = 1'b1;
         end
         apply_cfg(c, $urandom_range(0, 3) == 0);
         n = heavy ? $urandom_range(2, 5) : $urandom_range(4, 16);
         if (phase_no == 3) hold_off = 1'b1;
         for (k = 0; k < n; k++) send_frame(pick_pos());
         settle();
         phase_no++;
      end
      calm = 1'b0;

      $display("run: %0d frame positions over %0d register settings, %0d pixel writes checked",
               frames_sent, cfg_phases, pix_count);
      $display("run: clipped and empty segments, zero to full trails, both directions, rings");
      if (err_count == 0 && pending == 0)
         $display("tb_comet_tail_renderer: clean");
      else
         $display("tb_comet_tail_renderer: errors");
      $finish;
   end

endmodule

/* comet_tail_renderer.f */
+incdir+src
src/ctr_pkg.sv
src/ctr_divider.sv
src/comet_tail_renderer.sv
tb/comet_pixel_checker.sv
tb/tb_comet_tail_renderer.sv
